FILE: sv/number_theoretic_transform_assert.svh
// Assertion macros for the number theoretic transform block.
`ifndef NUMBER_THEORETIC_TRANSFORM_ASSERT_SVH
`define NUMBER_THEORETIC_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
`define NTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntt assertion failed");
`define NTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntt assertion failed");
`else
`define NTT_ASSERT_IMP(lbl, ante, cons)
`define NTT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/ntt_pkg.sv
// Package: constants, payload types and unit interfaces of the NTT block.
package ntt_pkg;
  localparam int VALUE_BITS = 30;
  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int LOG_MAX    = ADDR_W;
  localparam int LOG_W      = 4;
  localparam int SLOT_W     = 10;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int MUL_CNT_W  = $clog2(VALUE_BITS);

  localparam logic [VALUE_BITS-1:0] PRIME_RST = VALUE_BITS'(998244353);
  localparam logic [VALUE_BITS-1:0] ROOT_RST  = VALUE_BITS'(3);
  localparam logic [LOG_W-1:0]      LOG_RST   = LOG_W'(10);

  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOG   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [SLOT_W-1:0]     slot;
    logic [VALUE_BITS-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    logic                  finished;
  } out_item_t;

  typedef struct packed {
    logic                  go;
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     addr;
    logic [VALUE_BITS-1:0] wdata;
  } mem_req_t;
endpackage

FILE: sv/ntt_mulmod.sv
// Bit-serial modular multiplier: a*b mod p, one bit of b per cycle, a < p.
module ntt_mulmod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ntt_pkg::VALUE_BITS-1:0] p,
  input  ntt_pkg::mul_req_t             req,
  output ntt_pkg::mul_rsp_t             rsp
);
  import ntt_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [MUL_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [VALUE_BITS-1:0] a_r, a_nxt;
  logic [VALUE_BITS-1:0] b_r, b_nxt;
  logic [VALUE_BITS-1:0] p_r, p_nxt;
  logic [VALUE_BITS+1:0] t, p1, p2;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    p1 = {2'b00, p_r};
    p2 = {1'b0, p_r, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + (b_r[cnt_r] ? {2'b00, a_r} : '0);
    if (busy_r) begin
      if (t >= p2) begin
        acc_nxt = VALUE_BITS'(t - p2);
      end else if (t >= p1) begin
        acc_nxt = VALUE_BITS'(t - p1);
      end else begin
        acc_nxt = VALUE_BITS'(t);
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else if (req.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = MUL_CNT_W'(VALUE_BITS - 1);
      acc_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      p_nxt    = p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    p_r   <= p_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = (p_r < VALUE_BITS'(2)) ? '0 : acc_r;
endmodule

FILE: sv/ntt_store.sv
// Coefficient store: single-port memory with registered read data.
module ntt_store (
  input  logic                           clk,
  input  ntt_pkg::mem_req_t              req,
  output logic [ntt_pkg::VALUE_BITS-1:0] rdata
);
  import ntt_pkg::*;

  logic [VALUE_BITS-1:0] mem [MAX_POINTS];
  logic [VALUE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;
endmodule

FILE: sv/number_theoretic_transform.sv
// Top level: radix-2 NTT over a stored coefficient array, one shared modmul unit.
//
//   channel  signals                      handshake
//   input    start, busy, in_item         taken when start && !busy
//   result   out_valid, out_item          one-cycle strobe, never stalled
//   config   cfg_we, cfg_index, cfg_wdata written when cfg_we, no wait
//
// A transform reduces every coefficient mod p, permutes them into bit-reversed order,
// then per stage computes the stage root (and its inverse in inverse mode) and runs
// the butterflies; inverse mode ends with scaling by 1/n. Loads, reduction, roots,
// butterflies and scaling all run on the shared bit-serial modular multiplier.
// Reset is synchronous; the store needs no clearing. Results cannot stall.
`include "number_theoretic_transform_assert.svh"
module number_theoretic_transform (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ntt_pkg::in_item_t               in_item,
  output logic                            out_valid,
  output ntt_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [ntt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ntt_pkg::VALUE_BITS-1:0]  cfg_wdata
);
  import ntt_pkg::*;

  typedef enum logic [29:0] {
    ST_IDLE    = 30'd1 << 0,  ST_LD_WAIT = 30'd1 << 1,  ST_RD_WAIT = 30'd1 << 2,
    ST_NOP     = 30'd1 << 3,  ST_RED_RD  = 30'd1 << 4,  ST_RED_GO  = 30'd1 << 5,
    ST_RED_WT  = 30'd1 << 6,  ST_BR_CHK  = 30'd1 << 7,  ST_BR_RDJ  = 30'd1 << 8,
    ST_BR_SWP  = 30'd1 << 9,  ST_BR_WJ   = 30'd1 << 10, ST_BR_NXT  = 30'd1 << 11,
    ST_STG     = 30'd1 << 12, ST_ROOT1   = 30'd1 << 13, ST_ROOT2   = 30'd1 << 14,
    ST_BF_INIT = 30'd1 << 15, ST_BF_RDU  = 30'd1 << 16, ST_BF_RDV  = 30'd1 << 17,
    ST_BF_MUL  = 30'd1 << 18, ST_BF_WT   = 30'd1 << 19, ST_BF_WD   = 30'd1 << 20,
    ST_BF_WW   = 30'd1 << 21, ST_POST    = 30'd1 << 22, ST_SC_RD   = 30'd1 << 23,
    ST_SC_GO   = 30'd1 << 24, ST_SC_WT   = 30'd1 << 25, ST_PW_SQ0  = 30'd1 << 26,
    ST_PW_LOOP = 30'd1 << 27, ST_PW_MA   = 30'd1 << 28, ST_PW_MS   = 30'd1 << 29
  } state_t;

  state_t                state_r, state_nxt, pw_ret_r, pw_ret_nxt;
  logic [VALUE_BITS-1:0] p_r, g_r;
  logic                  inv_r;
  logic [LOG_W-1:0]      lg_r;
  logic [CNT_W-1:0]      i_r, i_nxt, st_r, st_nxt, j_r, j_nxt;
  logic [LOG_W-1:0]      stage_r, stage_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [VALUE_BITS-1:0] w_r, w_nxt, ta_r, ta_nxt, tb_r, tb_nxt;
  logic [VALUE_BITS-1:0] ex_r, ex_nxt, acc_r, acc_nxt, sq_r, sq_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  mul_req_t              mreq;
  mul_rsp_t              mrsp;
  mem_req_t              mem;
  logic [VALUE_BITS-1:0] rdata;

  logic [LOG_W-1:0]      lg_eff;
  logic [CNT_W-1:0]      n, h, len;
  logic [ADDR_W-1:0]     jrev;
  logic [VALUE_BITS-1:0] one, fermat, stg_ex;
  logic [VALUE_BITS:0]   sum, dif;
  logic [VALUE_BITS-1:0] bf_s, bf_d;

  function automatic logic [ADDR_W-1:0] bitrev(input logic [ADDR_W-1:0] x);
    logic [ADDR_W-1:0] r;
    for (int k = 0; k < ADDR_W; k++) begin
      r[k] = x[ADDR_W-1-k];
    end
    return r;
  endfunction

  ntt_mulmod u_mul (.clk(clk), .rst_n(rst_n), .p(p_r), .req(mreq), .rsp(mrsp));
  ntt_store  u_mem (.clk(clk), .req(mem), .rdata(rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r   <= PRIME_RST;
      g_r   <= ROOT_RST;
      inv_r <= 1'b0;
      lg_r  <= LOG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRIME: p_r   <= cfg_wdata;
        REG_ROOT:  g_r   <= cfg_wdata;
        REG_INV:   inv_r <= cfg_wdata[0];
        REG_LOG:   lg_r  <= cfg_wdata[LOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lg_eff = (lg_r > LOG_W'(LOG_MAX)) ? LOG_W'(LOG_MAX) : lg_r;
    n      = CNT_W'(1) << lg_eff;
    len    = CNT_W'(1) << stage_r;
    h      = CNT_W'(1) << (stage_r - 1'b1);
    jrev   = bitrev(i_r[ADDR_W-1:0]) >> (LOG_W'(LOG_MAX) - lg_eff);
    one    = (p_r < VALUE_BITS'(2)) ? '0 : VALUE_BITS'(1);
    fermat = (p_r < VALUE_BITS'(2)) ? '0 : p_r - VALUE_BITS'(2);
    stg_ex = (p_r == '0) ? '0 : (p_r - VALUE_BITS'(1)) >> stage_r;
    sum    = {1'b0, ta_r} + {1'b0, mrsp.res};
    bf_s   = (sum >= {1'b0, p_r}) ? VALUE_BITS'(sum - {1'b0, p_r}) : VALUE_BITS'(sum);
    dif    = (ta_r >= mrsp.res) ? {1'b0, ta_r} - {1'b0, mrsp.res}
                                : {1'b0, ta_r} + {1'b0, p_r} - {1'b0, mrsp.res};
    bf_d   = VALUE_BITS'(dif);
    if (p_r < VALUE_BITS'(2)) begin
      bf_s = '0;
      bf_d = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pw_ret_nxt    = pw_ret_r;
    i_nxt         = i_r;
    st_nxt        = st_r;
    j_nxt         = j_r;
    stage_nxt     = stage_r;
    slot_nxt      = slot_r;
    w_nxt         = w_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    ex_nxt        = ex_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mreq          = '{go: 1'b0, a: '0, b: '0};
    mem           = '{we: 1'b0, addr: '0, wdata: '0};
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          slot_nxt = in_item.slot;
          i_nxt    = '0;
          unique case (in_item.action)
            ACT_LOAD: begin
              mreq      = '{go: 1'b1, a: one, b: in_item.load_value};
              state_nxt = ST_LD_WAIT;
            end
            ACT_RUN:  state_nxt = ST_RED_RD;
            ACT_READ: begin
              mem.addr  = in_item.slot[ADDR_W-1:0];
              state_nxt = ST_RD_WAIT;
            end
            default:  state_nxt = ST_NOP;
          endcase
        end
      end
      ST_LD_WAIT: begin
        if (mrsp.done) begin
          mem           = '{we: 1'b1, addr: slot_r[ADDR_W-1:0], wdata: mrsp.res};
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{read_value: '0, finished: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      ST_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{read_value: rdata, finished: 1'b1};
        state_nxt     = ST_IDLE;
      end
      ST_NOP: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{read_value: '0, finished: 1'b0};
        state_nxt     = ST_IDLE;
      end
      ST_RED_RD: begin
        mem.addr  = i_r[ADDR_W-1:0];
        state_nxt = ST_RED_GO;
      end
      ST_RED_GO: begin
        mreq      = '{go: 1'b1, a: one, b: rdata};
        state_nxt = ST_RED_WT;
      end
      ST_RED_WT: begin
        if (mrsp.done) begin
          mem = '{we: 1'b1, addr: i_r[ADDR_W-1:0], wdata: mrsp.res};
          if (i_r + 1'b1 == n) begin
            i_nxt     = '0;
            state_nxt = ST_BR_CHK;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_RED_RD;
          end
        end
      end
      ST_BR_CHK: begin
        if (i_r[ADDR_W-1:0] < jrev) begin
          mem.addr  = i_r[ADDR_W-1:0];
          state_nxt = ST_BR_RDJ;
        end else begin
          state_nxt = ST_BR_NXT;
        end
      end
      ST_BR_RDJ: begin
        ta_nxt    = rdata;
        mem.addr  = jrev;
        state_nxt = ST_BR_SWP;
      end
      ST_BR_SWP: begin
        mem       = '{we: 1'b1, addr: i_r[ADDR_W-1:0], wdata: rdata};
        state_nxt = ST_BR_WJ;
      end
      ST_BR_WJ: begin
        mem       = '{we: 1'b1, addr: jrev, wdata: ta_r};
        state_nxt = ST_BR_NXT;
      end
      ST_BR_NXT: begin
        if (i_r + 1'b1 == n) begin
          stage_nxt = LOG_W'(1);
          state_nxt = (lg_eff == '0) ? ST_POST : ST_STG;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_BR_CHK;
        end
      end
      ST_STG: begin
        mreq       = '{go: 1'b1, a: one, b: g_r};
        ex_nxt     = stg_ex;
        acc_nxt    = one;
        pw_ret_nxt = ST_ROOT1;
        state_nxt  = ST_PW_SQ0;
      end
      ST_ROOT1: begin
        if (inv_r) begin
          mreq       = '{go: 1'b1, a: one, b: acc_r};
          ex_nxt     = fermat;
          acc_nxt    = one;
          pw_ret_nxt = ST_ROOT2;
          state_nxt  = ST_PW_SQ0;
        end else begin
          state_nxt = ST_BF_INIT;
        end
      end
      ST_ROOT2: state_nxt = ST_BF_INIT;
      ST_BF_INIT: begin
        st_nxt    = '0;
        j_nxt     = '0;
        w_nxt     = one;
        state_nxt = ST_BF_RDU;
      end
      ST_BF_RDU: begin
        mem.addr  = ADDR_W'(st_r + j_r);
        state_nxt = ST_BF_RDV;
      end
      ST_BF_RDV: begin
        ta_nxt    = rdata;
        mem.addr  = ADDR_W'(st_r + j_r + h);
        state_nxt = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        mreq      = '{go: 1'b1, a: w_r, b: rdata};
        state_nxt = ST_BF_WT;
      end
      ST_BF_WT: begin
        if (mrsp.done) begin
          mem       = '{we: 1'b1, addr: ADDR_W'(st_r + j_r), wdata: bf_s};
          tb_nxt    = bf_d;
          state_nxt = ST_BF_WD;
        end
      end
      ST_BF_WD: begin
        mem       = '{we: 1'b1, addr: ADDR_W'(st_r + j_r + h), wdata: tb_r};
        mreq      = '{go: 1'b1, a: w_r, b: acc_r};
        state_nxt = ST_BF_WW;
      end
      ST_BF_WW: begin
        if (mrsp.done) begin
          w_nxt = mrsp.res;
          if (j_r + 1'b1 == h) begin
            j_nxt = '0;
            w_nxt = one;
            if (st_r + len == n) begin
              if (stage_r == lg_eff) begin
                state_nxt = ST_POST;
              end else begin
                stage_nxt = stage_r + 1'b1;
                state_nxt = ST_STG;
              end
            end else begin
              st_nxt    = st_r + len;
              state_nxt = ST_BF_RDU;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_BF_RDU;
          end
        end
      end
      ST_POST: begin
        i_nxt = '0;
        if (inv_r) begin
          mreq       = '{go: 1'b1, a: one, b: VALUE_BITS'(n)};
          ex_nxt     = fermat;
          acc_nxt    = one;
          pw_ret_nxt = ST_SC_RD;
          state_nxt  = ST_PW_SQ0;
        end else begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{read_value: '0, finished: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      ST_SC_RD: begin
        mem.addr  = i_r[ADDR_W-1:0];
        state_nxt = ST_SC_GO;
      end
      ST_SC_GO: begin
        mreq      = '{go: 1'b1, a: acc_r, b: rdata};
        state_nxt = ST_SC_WT;
      end
      ST_SC_WT: begin
        if (mrsp.done) begin
          mem = '{we: 1'b1, addr: i_r[ADDR_W-1:0], wdata: mrsp.res};
          if (i_r + 1'b1 == n) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{read_value: '0, finished: 1'b1};
            state_nxt     = ST_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_SC_RD;
          end
        end
      end
      ST_PW_SQ0: begin
        if (mrsp.done) begin
          sq_nxt    = mrsp.res;
          state_nxt = ST_PW_LOOP;
        end
      end
      ST_PW_LOOP: begin
        if (ex_r == '0) begin
          state_nxt = pw_ret_r;
        end else if (ex_r[0]) begin
          mreq      = '{go: 1'b1, a: acc_r, b: sq_r};
          state_nxt = ST_PW_MA;
        end else begin
          mreq      = '{go: 1'b1, a: sq_r, b: sq_r};
          state_nxt = ST_PW_MS;
        end
      end
      ST_PW_MA: begin
        if (mrsp.done) begin
          acc_nxt   = mrsp.res;
          mreq      = '{go: 1'b1, a: sq_r, b: sq_r};
          state_nxt = ST_PW_MS;
        end
      end
      ST_PW_MS: begin
        if (mrsp.done) begin
          sq_nxt    = mrsp.res;
          ex_nxt    = ex_r >> 1;
          state_nxt = ST_PW_LOOP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pw_ret_r    <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pw_ret_r    <= pw_ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    st_r       <= st_nxt;
    j_r        <= j_nxt;
    stage_r    <= stage_nxt;
    slot_r     <= slot_nxt;
    w_r        <= w_nxt;
    ta_r       <= ta_nxt;
    tb_r       <= tb_nxt;
    ex_r       <= ex_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `NTT_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `NTT_ASSERT_IMP(a_out_after_work, out_valid, $past(busy))
  `NTT_ASSERT_IMP(a_zero_unfinished, out_valid && !out_item.finished,
                  out_item.read_value == '0)
endmodule

FILE: test/ntt_checker.sv
// Checker for the NTT block: mirrors the coefficient store, predicts each result, compares.
`timescale 1ns / 1ps
module ntt_checker
  import ntt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_wdata,
  output int        errors,
  output int        pending
);
  logic [VALUE_BITS-1:0] coeffs [MAX_POINTS];
  logic [63:0] prime, root_gen;
  logic        inv_mode;
  logic [LOG_W-1:0] log_len;
  out_item_t   expected_results[$];

  function automatic logic [63:0] mod_red(logic [63:0] x, logic [63:0] p);
    return (p < 2) ? 64'd0 : x % p;
  endfunction

  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    if (p < 2) return 64'd0;
    return ((a % p) * (b % p)) % p;
  endfunction

  function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] ex, logic [63:0] p);
    logic [63:0] acc, sq;
    acc = mod_red(1, p);
    sq  = mod_red(base, p);
    while (ex != 0) begin
      if (ex[0]) acc = mod_mul(acc, sq, p);
      sq = mod_mul(sq, sq, p);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic void run_ntt();
    logic [63:0] p, fermat, ex, w, wroot, u, v, s, d, ninv;
    logic [VALUE_BITS-1:0] t;
    int lg, n, i, j, k, len, st, h;
    p = prime;
    fermat = (p >= 2) ? p - 2 : 64'd0;
    lg = (log_len > LOG_MAX) ? LOG_MAX : int'(log_len);
    n = 1 << lg;
    for (i = 0; i < n; i++) coeffs[i] = VALUE_BITS'(mod_red(coeffs[i], p));
    for (i = 0; i < n; i++) begin
      j = 0;
      for (k = 0; k < lg; k++)
        if ((i >> k) & 1) j |= 1 << (lg - 1 - k);
      if (i < j) begin
        t = coeffs[i];
        coeffs[i] = coeffs[j];
        coeffs[j] = t;
      end
    end
    for (len = 2; len <= n; len = len << 1) begin
      ex = (p >= 1) ? (p - 1) / len : 64'd0;
      wroot = mod_pow(root_gen, ex, p);
      if (inv_mode) wroot = mod_pow(wroot, fermat, p);
      h = len >> 1;
      for (st = 0; st < n; st += len) begin
        w = mod_red(1, p);
        for (j = 0; j < h; j++) begin
          u = coeffs[st + j];
          v = mod_mul(coeffs[st + j + h], w, p);
          s = u + v;
          d = (u >= v) ? u - v : u + p - v;
          if (s >= p) s = s - p;
          if (p < 2) begin
            s = 0;
            d = 0;
          end
          coeffs[st + j]     = VALUE_BITS'(s);
          coeffs[st + j + h] = VALUE_BITS'(d);
          w = mod_mul(w, wroot, p);
        end
      end
    end
    if (inv_mode) begin
      ninv = mod_pow(mod_red(n, p), fermat, p);
      for (i = 0; i < n; i++) coeffs[i] = VALUE_BITS'(mod_mul(coeffs[i], ninv, p));
    end
  endfunction

  function automatic out_item_t predict_action(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.action)
      ACT_LOAD: begin
        coeffs[it.slot] = VALUE_BITS'(mod_red(it.load_value, prime));
        r.finished = 1'b1;
      end
      ACT_RUN: begin
        run_ntt();
        r.finished = 1'b1;
      end
      ACT_READ: begin
        r.read_value = coeffs[it.slot];
        r.finished   = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      prime    <= PRIME_RST;
      root_gen <= ROOT_RST;
      inv_mode <= 1'b0;
      log_len  <= LOG_RST;
      errors   <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PRIME: prime    <= cfg_wdata;
          REG_ROOT:  root_gen <= cfg_wdata;
          REG_INV:   inv_mode <= cfg_wdata[0];
          REG_LOG:   log_len  <= cfg_wdata[LOG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected item, actual value %h", $time, out_item);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_item.read_value !== want.read_value || out_item.finished !== want.finished) begin
            $display("%0t: mismatch, expected value %h/%b, actual value %h/%b", $time,
                     want.read_value, want.finished, out_item.read_value, out_item.finished);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_action(in_item));
    end
  end
endmodule

FILE: test/tb_top.sv
// Testbench top: drives the NTT block with directed and random items and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  import ntt_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000000;

  logic clk, rst_n, start, busy, out_valid, cfg_we;
  in_item_t  in_item;
  out_item_t out_item;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [VALUE_BITS-1:0] cfg_wdata;
  int errors, pending, quiet_cycles;

  number_theoretic_transform i_dut (.*);

  ntt_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[number_theoretic_transform] ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] slot,
                      logic [VALUE_BITS-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{action: act, slot: slot, load_value: val};
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [VALUE_BITS-1:0] p, logic [VALUE_BITS-1:0] g,
                           logic inv, logic [LOG_W-1:0] lg);
    drain();
    write_reg(REG_PRIME, p);
    write_reg(REG_ROOT, g);
    write_reg(REG_INV, VALUE_BITS'(inv));
    write_reg(REG_LOG, VALUE_BITS'(lg));
  endtask

  logic [VALUE_BITS-1:0] set_p [9] = '{998244353, 469762049, 1004535809, 3, 3,
                                       1073741823, 1, 0, 998244353};
  logic [VALUE_BITS-1:0] set_g [9] = '{3, 3, 3, 2, 2, 1073741822, 1, 5, 3};
  logic set_inv [9] = '{1, 0, 1, 0, 1, 0, 1, 0, 0};
  logic [LOG_W-1:0] set_log [9] = '{4, 3, 2, 1, 1, 4, 3, 0, 5};

  initial begin
    int k, i, r, n;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every action, value equal to the prime, inverse round trip
    write_reg(REG_LOG, 1);
    send(ACT_LOAD, 0, 30'h3FFFFFFF);
    send(ACT_LOAD, 1, 998244353);
    send(ACT_LOAD, 1023, 0);
    send(ACT_READ, 0, 30'h3FFFFFFF);
    send(ACT_READ, 1, 0);
    send(ACT_READ, 1023, 0);
    send(ACT_NOP, 10'h3FF, 30'h3FFFFFFF);
    send(ACT_NOP, 0, 0);
    send(ACT_LOAD, 1, 12345);
    send(ACT_RUN, 10'h3FF, 30'h3FFFFFFF);
    send(ACT_READ, 0, 0);
    send(ACT_READ, 1, 0);
    configure(998244353, 3, 1, 1);
    send(ACT_RUN, 0, 0);
    send(ACT_READ, 0, 0);
    send(ACT_READ, 1, 0);

    // fill the whole store, then a full-length transform
    configure(998244353, 3, 0, 10);
    for (i = 0; i < MAX_POINTS; i++) begin
      send(ACT_LOAD, i, $urandom());
      if ($urandom_range(4) == 0) send(ACT_READ, $urandom_range(i), $urandom());
    end
    send(ACT_RUN, $urandom(), $urandom());
    for (i = 0; i < 30; i++) send(ACT_READ, $urandom(), $urandom());

    // random phases across the register settings
    for (k = 0; k < 9; k++) begin
      configure(set_p[k], set_g[k], set_inv[k], set_log[k]);
      n = 1 << set_log[k];
      for (i = 0; i < 25; i++) begin
        r = $urandom_range(99);
        if (r < 50) send(ACT_LOAD, $urandom_range(n - 1), $urandom());
        else if (r < 58) send(ACT_LOAD, $urandom(), $urandom());
        else if (r < 85) send(ACT_READ, $urandom(), $urandom());
        else if (r < 90) send(ACT_NOP, $urandom(), $urandom());
        else send(ACT_RUN, $urandom(), $urandom());
      end
      send(ACT_RUN, 0, 0);
      for (i = 0; i < n && i < 8; i++) send(ACT_READ, i, $urandom());
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("[number_theoretic_transform] OK");
    else $display("[number_theoretic_transform] ERROR");
    $finish;
  end
endmodule

FILE: files.f
+incdir+sv
sv/ntt_pkg.sv
sv/ntt_mulmod.sv
sv/ntt_store.sv
sv/number_theoretic_transform.sv
test/ntt_checker.sv
test/tb_top.sv
